// ===== design/segment_intersection_test_macros.svh =====
// Assertion macros shared by the segment intersection test RTL.
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SIT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SIT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SIT_ASSERT_IMP(name, ante, cons)
`define SIT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== design/sit_pkg.sv =====
// Types, widths and constants of the segment intersection test.
package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int TOL_BITS   = 15;
    localparam int AREA_SHIFT = 8;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int AREA_BITS  = PROD_BITS + 1;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [AREA_BITS-1:0]  t_area;
    typedef logic [TOL_BITS-1:0]          t_tol;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_diff x;
        t_diff y;
    } t_vec;

    // area = ux * vy - uy * vx
    typedef struct packed {
        t_diff ux;
        t_diff vy;
        t_diff uy;
        t_diff vx;
    } t_quad;

    // endpoint lies in the widened box of the other segment
    typedef struct packed {
        logic c_in_ab;
        logic d_in_ab;
        logic a_in_cd;
        logic b_in_cd;
    } t_touch;

endpackage

// ===== design/segment_intersection_test.sv =====
// Top level: segment intersection test, valid/stall pipeline with tolerance register.
// Throughput: one segment pair per cycle unless stalled; four register stages (differences,
// products, area difference, tolerance compare) all advance together.
// A stalled result freezes the whole pipeline; o_stall follows i_stall while a result waits.
// Reset (synchronous, active low) clears all valid bits and sets the tolerance to 1.
`include "segment_intersection_test_macros.svh"

module segment_intersection_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sit_pkg::TOL_BITS-1:0]           i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_first_start_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_first_start_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_first_end_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_first_end_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_second_start_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_second_start_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_second_end_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  i_second_end_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_intersects
);

    sit_pkg::t_tol   r_tolerance;
    logic            r_v1, r_v2, r_v3, r_v4;
    logic            en;
    sit_pkg::t_point pa, pb, pc, pd;
    sit_pkg::t_quad  q_abc, q_abd, q_cda, q_cdb;
    sit_pkg::t_vec   v_ca, v_cb, v_da, v_db, v_ac, v_ad, v_bc, v_bd;
    sit_pkg::t_area  a_abc, a_abd, a_cda, a_cdb;
    logic            c_in_ab, d_in_ab, a_in_cd, b_in_cd;
    sit_pkg::t_touch touch;

    // pipeline moves unless a finished result is held by the sink
    assign en      = !(r_v4 && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= sit_pkg::TOL_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tolerance <= i_cfg_data;
            end
            if (en) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
        end
    end

    assign pa = '{x: i_first_start_x,  y: i_first_start_y};
    assign pb = '{x: i_first_end_x,    y: i_first_end_y};
    assign pc = '{x: i_second_start_x, y: i_second_start_y};
    assign pd = '{x: i_second_end_x,   y: i_second_end_y};

    sit_front u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (pa),
        .i_b   (pb),
        .i_c   (pc),
        .i_d   (pd),
        .o_abc (q_abc),
        .o_abd (q_abd),
        .o_cda (q_cda),
        .o_cdb (q_cdb),
        .o_ca  (v_ca),
        .o_cb  (v_cb),
        .o_da  (v_da),
        .o_db  (v_db),
        .o_ac  (v_ac),
        .o_ad  (v_ad),
        .o_bc  (v_bc),
        .o_bd  (v_bd)
    );

    sit_area u_area_abc (.i_clk(i_clk), .i_en(en), .i_quad(q_abc), .o_area(a_abc));
    sit_area u_area_abd (.i_clk(i_clk), .i_en(en), .i_quad(q_abd), .o_area(a_abd));
    sit_area u_area_cda (.i_clk(i_clk), .i_en(en), .i_quad(q_cda), .o_area(a_cda));
    sit_area u_area_cdb (.i_clk(i_clk), .i_en(en), .i_quad(q_cdb), .o_area(a_cdb));

    sit_box u_box_c (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_tol       (r_tolerance),
        .i_to_first  (v_ca),
        .i_to_second (v_cb),
        .o_inside    (c_in_ab)
    );

    sit_box u_box_d (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_tol       (r_tolerance),
        .i_to_first  (v_da),
        .i_to_second (v_db),
        .o_inside    (d_in_ab)
    );

    sit_box u_box_a (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_tol       (r_tolerance),
        .i_to_first  (v_ac),
        .i_to_second (v_ad),
        .o_inside    (a_in_cd)
    );

    sit_box u_box_b (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_tol       (r_tolerance),
        .i_to_first  (v_bc),
        .i_to_second (v_bd),
        .o_inside    (b_in_cd)
    );

    assign touch = '{c_in_ab: c_in_ab, d_in_ab: d_in_ab, a_in_cd: a_in_cd, b_in_cd: b_in_cd};

    sit_judge u_judge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tol   (r_tolerance),
        .i_abc   (a_abc),
        .i_abd   (a_abd),
        .i_cda   (a_cda),
        .i_cdb   (a_cdb),
        .i_touch (touch),
        .o_hit   (o_intersects)
    );

    `SIT_ASSERT_NEXT(a_transfer_enters, i_valid && !o_stall, r_v1)
    `SIT_ASSERT_NEXT(a_stall_freezes, o_valid && i_stall, $stable({r_v1, r_v2, r_v3}) && o_valid)
    `SIT_ASSERT_NEXT(a_last_stage_drains, en && r_v3, o_valid)

endmodule

// ===== design/sit_front.sv =====
// Stage 1: registered endpoint differences for the areas and box tests.
module sit_front (
    input  logic            i_clk,
    input  logic            i_en,
    input  sit_pkg::t_point i_a,
    input  sit_pkg::t_point i_b,
    input  sit_pkg::t_point i_c,
    input  sit_pkg::t_point i_d,
    output sit_pkg::t_quad  o_abc,
    output sit_pkg::t_quad  o_abd,
    output sit_pkg::t_quad  o_cda,
    output sit_pkg::t_quad  o_cdb,
    output sit_pkg::t_vec   o_ca,
    output sit_pkg::t_vec   o_cb,
    output sit_pkg::t_vec   o_da,
    output sit_pkg::t_vec   o_db,
    output sit_pkg::t_vec   o_ac,
    output sit_pkg::t_vec   o_ad,
    output sit_pkg::t_vec   o_bc,
    output sit_pkg::t_vec   o_bd
);

    function automatic sit_pkg::t_vec vsub(sit_pkg::t_point p, sit_pkg::t_point q);
        sit_pkg::t_coord px;
        sit_pkg::t_coord py;
        sit_pkg::t_coord qx;
        sit_pkg::t_coord qy;
        sit_pkg::t_vec   r;
        px  = p.x;
        py  = p.y;
        qx  = q.x;
        qy  = q.y;
        r.x = sit_pkg::t_diff'(px) - sit_pkg::t_diff'(qx);
        r.y = sit_pkg::t_diff'(py) - sit_pkg::t_diff'(qy);
        return r;
    endfunction

    sit_pkg::t_vec r_ba, r_dc;
    sit_pkg::t_vec r_ca, r_cb, r_da, r_db;
    sit_pkg::t_vec r_ac, r_ad, r_bc, r_bd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ba <= vsub(i_b, i_a);
            r_dc <= vsub(i_d, i_c);
            r_ca <= vsub(i_c, i_a);
            r_cb <= vsub(i_c, i_b);
            r_da <= vsub(i_d, i_a);
            r_db <= vsub(i_d, i_b);
            r_ac <= vsub(i_a, i_c);
            r_ad <= vsub(i_a, i_d);
            r_bc <= vsub(i_b, i_c);
            r_bd <= vsub(i_b, i_d);
        end
    end

    assign o_abc = '{ux: r_ba.x, vy: r_ca.y, uy: r_ba.y, vx: r_ca.x};
    assign o_abd = '{ux: r_ba.x, vy: r_da.y, uy: r_ba.y, vx: r_da.x};
    assign o_cda = '{ux: r_dc.x, vy: r_ac.y, uy: r_dc.y, vx: r_ac.x};
    assign o_cdb = '{ux: r_dc.x, vy: r_bc.y, uy: r_dc.y, vx: r_bc.x};

    assign o_ca = r_ca;
    assign o_cb = r_cb;
    assign o_da = r_da;
    assign o_db = r_db;
    assign o_ac = r_ac;
    assign o_ad = r_ad;
    assign o_bc = r_bc;
    assign o_bd = r_bd;

endmodule

// ===== design/sit_area.sv =====
// Stages 2 and 3: one orientation cross product, products then difference.
module sit_area (
    input  logic           i_clk,
    input  logic           i_en,
    input  sit_pkg::t_quad i_quad,
    output sit_pkg::t_area o_area
);

    sit_pkg::t_diff ux, vy, uy, vx;
    sit_pkg::t_prod n_p0, n_p1;
    sit_pkg::t_prod r_p0, r_p1;
    sit_pkg::t_area r_area;

    always_comb begin
        ux   = i_quad.ux;
        vy   = i_quad.vy;
        uy   = i_quad.uy;
        vx   = i_quad.vx;
        n_p0 = sit_pkg::t_prod'(ux) * sit_pkg::t_prod'(vy);
        n_p1 = sit_pkg::t_prod'(uy) * sit_pkg::t_prod'(vx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_area <= sit_pkg::t_area'(r_p0) - sit_pkg::t_area'(r_p1);
        end
    end

    assign o_area = r_area;

endmodule

// ===== design/sit_box.sv =====
// Stages 2 and 3: widened bounding-box test of one endpoint.
module sit_box (
    input  logic          i_clk,
    input  logic          i_en,
    input  sit_pkg::t_tol i_tol,
    input  sit_pkg::t_vec i_to_first,   // endpoint minus first end of the other segment
    input  sit_pkg::t_vec i_to_second,  // endpoint minus second end
    output logic          o_inside
);

    // v in [min(f,s)-eps, max(f,s)+eps] expressed with v-f and v-s
    function automatic logic axis_in(sit_pkg::t_diff d1, sit_pkg::t_diff d2,
                                     sit_pkg::t_diff pe, sit_pkg::t_diff ne);
        return (d1 >= ne || d2 >= ne) && (d1 <= pe || d2 <= pe);
    endfunction

    sit_pkg::t_diff peps, neps;
    logic           n_inside;
    logic           r_inside_s2, r_inside_s3;

    always_comb begin
        peps     = sit_pkg::t_diff'({1'b0, i_tol});
        neps     = -peps;
        n_inside = axis_in(i_to_first.x, i_to_second.x, peps, neps)
                 && axis_in(i_to_first.y, i_to_second.y, peps, neps);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inside_s2 <= n_inside;
            r_inside_s3 <= r_inside_s2;
        end
    end

    assign o_inside = r_inside_s3;

endmodule

// ===== design/sit_judge.sv =====
// Stage 4: area compares against the tolerance, decision and result register.
module sit_judge (
    input  logic            i_clk,
    input  logic            i_en,
    input  sit_pkg::t_tol   i_tol,
    input  sit_pkg::t_area  i_abc,
    input  sit_pkg::t_area  i_abd,
    input  sit_pkg::t_area  i_cda,
    input  sit_pkg::t_area  i_cdb,
    input  sit_pkg::t_touch i_touch,
    output logic            o_hit
);

    function automatic logic opposite(sit_pkg::t_area x, sit_pkg::t_area y,
                                      sit_pkg::t_area pe, sit_pkg::t_area ne);
        return (x > pe && y < ne) || (x < ne && y > pe);
    endfunction

    function automatic logic near_zero(sit_pkg::t_area x, sit_pkg::t_area pe,
                                       sit_pkg::t_area ne);
        return x <= pe && x >= ne;
    endfunction

    sit_pkg::t_area pe, ne;
    logic           proper, touch, n_hit;
    logic           r_hit;

    always_comb begin
        pe     = sit_pkg::t_area'({i_tol, sit_pkg::AREA_SHIFT'(0)});
        ne     = -pe;
        proper = opposite(i_abc, i_abd, pe, ne) && opposite(i_cda, i_cdb, pe, ne);
        touch  = (near_zero(i_abc, pe, ne) && i_touch.c_in_ab)
               || (near_zero(i_abd, pe, ne) && i_touch.d_in_ab)
               || (near_zero(i_cda, pe, ne) && i_touch.a_in_cd)
               || (near_zero(i_cdb, pe, ne) && i_touch.b_in_cd);
        n_hit  = proper || touch;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule
